// ===== rtl/core/cw_pkg.sv =====
// ----------------------------------------------------------------------------
// Chebyshev waveshaper package
// Widths, formats and shared types for the Chebyshev polynomial waveshaper.
// ----------------------------------------------------------------------------
package cw_pkg;

    localparam int ORDER   = 8;
    localparam int NREG    = 8;
    localparam int XW      = 16;
    localparam int TW      = 18;
    localparam int PW      = XW + TW;
    localparam int RW      = PW - 13;
    localparam int AW      = 40;
    localparam int YW      = AW - 15;
    localparam int OW      = 19;
    localparam int WW      = 16;
    localparam int CFG_IW  = 4;
    localparam int REG_IW  = $clog2(NREG);

    typedef logic signed [XW-1:0] sample_t;
    typedef logic signed [TW-1:0] term_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [AW-1:0] acc_t;
    typedef logic signed [WW-1:0] weight_t;
    typedef logic signed [OW-1:0] out_t;
    typedef weight_t weights_t [NREG];

    localparam term_t   ONE_Q15       = term_t'(32768);
    localparam weight_t WEIGHT_T1_RST = weight_t'(32767);
    localparam logic signed [PW:0] STEP_ROUND = (PW+1)'(8192);
    localparam acc_t    ACC_ROUND     = acc_t'(16384);
    localparam logic signed [YW-1:0] OUT_MAX = YW'(262143);
    localparam logic signed [YW-1:0] OUT_MIN = -(YW'(262144));

    typedef struct packed {
        sample_t x;
        term_t   t1;
        term_t   t2;
        acc_t    acc;
    } stage_data_t;

endpackage

// ===== rtl/core/chebyshev_waveshaper.sv =====
// Each sample passes through the recurrence stage registers, then the tail's accumulate and output registers.
// Throughput: one sample per cycle while m_ready is high; each recurrence stage holds one sample.
// A stalled result holds only the stages behind it that are full.
// Reset is synchronous, active low: all stages empty, weight_t1 = 32767,
// the other weights zero.
// ----------------------------------------------------------------------------
// Chebyshev polynomial waveshaper
// Weighted sum of Chebyshev polynomials T1..T8 of a Q1.15 sample, Q4.15 out.
// ----------------------------------------------------------------------------
module chebyshev_waveshaper (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cw_pkg::sample_t             s_sample_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cw_pkg::out_t                m_sample_out,
    input  logic                        cfg_we,
    input  logic [cw_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [cw_pkg::WW-1:0]       cfg_data
);

    localparam int NSTAGE = cw_pkg::ORDER - 1;

    cw_pkg::weights_t    weights;
    cw_pkg::stage_data_t sdata [NSTAGE+1];
    logic [NSTAGE:0]     svalid;
    logic [NSTAGE:0]     sready;

    cw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .weights   (weights)
    );

    always_comb begin
        sdata[0].x   = s_sample_in;
        sdata[0].t1  = cw_pkg::term_t'(s_sample_in);
        sdata[0].t2  = cw_pkg::ONE_Q15;
        sdata[0].acc = '0;
    end

    assign svalid[0] = s_valid;
    assign s_ready   = sready[0];

    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        cw_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (svalid[k]),
            .in_ready  (sready[k]),
            .in_data   (sdata[k]),
            .weight    (weights[k]),
            .out_valid (svalid[k+1]),
            .out_ready (sready[k+1]),
            .out_data  (sdata[k+1])
        );
    end

    cw_tail u_tail (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (svalid[NSTAGE]),
        .in_ready   (sready[NSTAGE]),
        .in_data    (sdata[NSTAGE]),
        .weight     (weights[cw_pkg::ORDER-1]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sample (m_sample_out)
    );

endmodule

// ===== rtl/core/cw_cfg.sv =====
// ----------------------------------------------------------------------------
// Chebyshev waveshaper weight registers
// Holds the eight Q1.15 polynomial weights written through the config port.
// ----------------------------------------------------------------------------
module cw_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [cw_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [cw_pkg::WW-1:0]       cfg_data,
    output cw_pkg::weights_t            weights
);

    cw_pkg::weights_t weights_reg;
    cw_pkg::weights_t weights_next;

    always_comb begin
        weights_next = weights_reg;
        if (cfg_we && (cfg_index < cw_pkg::CFG_IW'(cw_pkg::NREG))) begin
            weights_next[cfg_index[cw_pkg::REG_IW-1:0]] = cw_pkg::weight_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < cw_pkg::NREG; i++) begin
                weights_reg[i] <= '0;
            end
            weights_reg[0] <= cw_pkg::WEIGHT_T1_RST;
        end else begin
            weights_reg <= weights_next;
        end
    end

    assign weights = weights_reg;

endmodule

// ===== rtl/core/cw_stage.sv =====
// ----------------------------------------------------------------------------
// Chebyshev waveshaper recurrence stage
// Forms Tn = round(2*x*T(n-1)) - T(n-2) and adds the weighted T(n-1) term.
// ----------------------------------------------------------------------------
module cw_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cw_pkg::stage_data_t  in_data,
    input  cw_pkg::weight_t      weight,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cw_pkg::stage_data_t  out_data
);

    logic                        valid_reg;
    cw_pkg::stage_data_t         data_reg;
    cw_pkg::stage_data_t         data_next;
    cw_pkg::prod_t               step_prod;
    cw_pkg::prod_t               weight_prod;
    logic signed [cw_pkg::PW:0]  step_sum;
    logic signed [cw_pkg::RW-1:0] step_rnd;
    logic signed [cw_pkg::RW-1:0] step_diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        step_prod   = cw_pkg::prod_t'(in_data.x) * cw_pkg::prod_t'(in_data.t1);
        weight_prod = cw_pkg::prod_t'(weight) * cw_pkg::prod_t'(in_data.t1);
        step_sum    = (cw_pkg::PW+1)'(step_prod) + cw_pkg::STEP_ROUND;
        step_rnd    = $signed(step_sum[cw_pkg::PW:14]);
        step_diff   = step_rnd - cw_pkg::RW'(in_data.t2);
        data_next.x   = in_data.x;
        data_next.t1  = cw_pkg::term_t'(step_diff);
        data_next.t2  = in_data.t1;
        data_next.acc = in_data.acc + cw_pkg::acc_t'(weight_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/cw_tail.sv =====
// ----------------------------------------------------------------------------
// Chebyshev waveshaper output stages
// Adds the last weighted term, then rounds the Q.30 sum to Q.15 and saturates.
// ----------------------------------------------------------------------------
module cw_tail (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cw_pkg::stage_data_t  in_data,
    input  cw_pkg::weight_t      weight,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cw_pkg::out_t         out_sample
);

    logic                         mac_valid_reg;
    cw_pkg::acc_t                 acc_reg;
    cw_pkg::acc_t                 acc_next;
    cw_pkg::prod_t                weight_prod;
    logic                         mac_ready;
    logic                         out_valid_reg;
    cw_pkg::out_t                 sample_reg;
    cw_pkg::out_t                 sample_next;
    cw_pkg::acc_t                 acc_rsum;
    logic signed [cw_pkg::YW-1:0] acc_rnd;

    assign mac_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mac_valid_reg || mac_ready;

    always_comb begin
        weight_prod = cw_pkg::prod_t'(weight) * cw_pkg::prod_t'(in_data.t1);
        acc_next    = in_data.acc + cw_pkg::acc_t'(weight_prod);
    end

    always_comb begin
        acc_rsum = acc_reg + cw_pkg::ACC_ROUND;
        acc_rnd  = $signed(acc_rsum[cw_pkg::AW-1:15]);
        if (acc_rnd > cw_pkg::OUT_MAX) begin
            sample_next = cw_pkg::out_t'(cw_pkg::OUT_MAX);
        end else if (acc_rnd < cw_pkg::OUT_MIN) begin
            sample_next = cw_pkg::out_t'(cw_pkg::OUT_MIN);
        end else begin
            sample_next = cw_pkg::out_t'(acc_rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                mac_valid_reg <= in_valid;
            end
            if (mac_ready) begin
                out_valid_reg <= mac_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            acc_reg <= acc_next;
        end
        if (mac_ready && mac_valid_reg) begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;

endmodule
